// File: design/first_fit_heap_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FFHA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffha assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FFHA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffha assertion failed");

`endif

// File: design/ffha_pkg.sv
package ffha_pkg;

	localparam int ES_W  = 17;
	localparam int TAG_W = 8;
	localparam int POS_W = 10;

	typedef struct packed {
		logic [ES_W-1:0]  size;
		logic             free;
		logic [TAG_W-1:0] tag;
	} entry_t;

	localparam logic [2:0] CMD_HOLD = 3'd0;
	localparam logic [2:0] CMD_SHL  = 3'd1;
	localparam logic [2:0] CMD_INS  = 3'd2;
	localparam logic [2:0] CMD_DEL  = 3'd3;
	localparam logic [2:0] CMD_WR   = 3'd4;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_DISABLED = 3'd1;
	localparam logic [2:0] STAT_ZERO     = 3'd2;
	localparam logic [2:0] STAT_OOM      = 3'd3;
	localparam logic [2:0] STAT_OUTSIDE  = 3'd4;
	localparam logic [2:0] STAT_DBLFREE  = 3'd5;
	localparam logic [2:0] STAT_NOENTRY  = 3'd6;

endpackage

// File: design/ffha_cell.sv
module ffha_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  ffha_pkg::cell_ctl_t ctl,
	input  ffha_pkg::entry_t   left,
	input  ffha_pkg::entry_t   right,
	input  ffha_pkg::entry_t   wdata,
	output ffha_pkg::entry_t   q
);
	import ffha_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	entry_t ent_q;

	assign q = ent_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_SHL: ent_q <= right;
			CMD_INS: begin
				if (MY_POS > ctl.pos) ent_q <= left;
				else if (MY_POS == ctl.pos) ent_q <= wdata;
			end
			CMD_DEL: begin
				if (MY_POS >= ctl.pos) ent_q <= right;
			end
			CMD_WR: begin
				if (MY_POS == ctl.pos) ent_q <= wdata;
			end
			default: ent_q <= ent_q;
		endcase
	end

endmodule

// File: design/first_fit_heap_allocator.sv
// Free requests outside the heap and zero-size allocates skip the ring walk and respond directly.
// All other requests walk the cell ring once on the way to a valid result word; one request
// is in flight at a time, and the ring rotates one entry per cycle past the head. A result word
// not yet taken holds the next answer back until the receiver takes it.
// Reset clears the entry count, heap end offset and output valid; append_enable resets
// to 1 and heap_bytes to 65536. Table contents are not cleared.
`include "first_fit_heap_allocator_assert.svh"

module first_fit_heap_allocator #(
	parameter int MAX_ENTRIES    = 64,
	parameter int HEADER_BYTES   = 16,
	parameter int HEAP_MAX_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // req_size[15:0], free_addr[31:16], type_tag[39:32]
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // data_addr[15:0], status[18:16], zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);
	import ffha_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int HEAP_CAP = (HEAP_MAX_BYTES > 131071) ? 131071 : HEAP_MAX_BYTES;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_WALK   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_MOD    = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;

	logic [2:0]  state_q;
	logic        append_en_q;
	logic [16:0] heap_bytes_q;
	logic [CW-1:0] count_q;
	logic [16:0] end_q;

	logic        op_q;
	logic [15:0] req_q;
	logic [15:0] fa_q;
	logic [7:0]  tag_q;

	logic [IW-1:0] idx_q;
	logic [17:0]   pos_q;
	logic          found_q;
	logic          need_next_q;
	logic [IW-1:0] hit_idx_q;
	logic [ES_W-1:0] hit_size_q;
	logic          hit_free_q;
	logic [7:0]    hit_tag_q;
	logic [17:0]   hit_pos_q;
	logic          prev_free_q;
	logic [ES_W-1:0] prev_size_q;
	logic          next_free_q;
	logic [ES_W-1:0] next_size_q;

	logic          ins_q;
	logic [1:0]    del_cnt_q;
	logic [IW-1:0] del_pos_q;
	entry_t        ins_data_q;

	logic [15:0] resp_addr_q;
	logic [2:0]  resp_st_q;
	logic        m_tvalid_q;
	logic [15:0] out_addr_q;
	logic [2:0]  out_st_q;

	cell_ctl_t ctl;
	entry_t    wdata;
	entry_t    cell_q [MAX_ENTRIES];
	entry_t    head;

	logic [16:0] limit;
	logic [16:0] avail;
	logic        room_ok;
	logic        cur_valid;
	logic        fit;
	logic        split_ok;
	logic        addr_match;
	logic        s_acc;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, out_st_q, out_addr_q};
	assign head     = cell_q[0];

	assign limit = (heap_bytes_q > 17'(HEAP_CAP)) ? 17'(HEAP_CAP) : heap_bytes_q;
	assign avail = (limit > end_q) ? (limit - end_q) : 17'd0;
	assign room_ok = {1'b0, avail} > (18'(HEADER_BYTES) + {2'b0, req_q});

	assign cur_valid  = CW'(idx_q) < count_q;
	assign split_ok   = ((head.size - {1'b0, req_q}) > ES_W'(HEADER_BYTES))
		&& (count_q < CW'(MAX_ENTRIES));
	assign fit        = head.free && (head.size >= {1'b0, req_q})
		&& ((head.size == {1'b0, req_q}) || split_ok);
	assign addr_match = (pos_q + 18'(HEADER_BYTES)) == {2'b0, fa_q};

	genvar k;
	generate
		for (k = 0; k < MAX_ENTRIES; k++) begin : g_cell
			entry_t lft;
			entry_t rgt;
			if (k == 0) begin : g_first
				assign lft = wdata;
			end else begin : g_mid_l
				assign lft = cell_q[k-1];
			end
			if (k == MAX_ENTRIES - 1) begin : g_last
				assign rgt = cell_q[0];
			end else begin : g_mid_r
				assign rgt = cell_q[k+1];
			end
			ffha_cell #(.IDX(k)) u_cell (
				.clk  (clk),
				.ctl  (ctl),
				.left (lft),
				.right(rgt),
				.wdata(wdata),
				.q    (cell_q[k])
			);
		end
	endgenerate

	// Command to the ring for this cycle
	always_comb begin
		ctl.cmd = CMD_HOLD;
		ctl.pos = '0;
		wdata   = ins_data_q;
		case (state_q)
			S_WALK: ctl.cmd = CMD_SHL;
			S_DECIDE: begin
				if (!op_q) begin
					wdata.size = {1'b0, req_q};
					wdata.free = 1'b0;
					wdata.tag  = tag_q;
					if (found_q) begin
						ctl.cmd = CMD_WR;
						ctl.pos = POS_W'(hit_idx_q);
					end else if (append_en_q && count_q < CW'(MAX_ENTRIES) && room_ok) begin
						ctl.cmd = CMD_WR;
						ctl.pos = POS_W'(count_q);
					end
				end else if (found_q && !hit_free_q) begin
					ctl.cmd   = CMD_WR;
					wdata.free = 1'b1;
					wdata.tag  = 8'd0;
					if (prev_free_q) begin
						ctl.pos = POS_W'(hit_idx_q - IW'(1));
						wdata.size = ES_W'(prev_size_q + ES_W'(HEADER_BYTES) + hit_size_q
							+ (next_free_q ? (ES_W'(HEADER_BYTES) + next_size_q) : '0));
					end else if (next_free_q) begin
						ctl.pos = POS_W'(hit_idx_q);
						wdata.size = ES_W'(hit_size_q + ES_W'(HEADER_BYTES) + next_size_q);
					end else begin
						ctl.pos = POS_W'(hit_idx_q);
						wdata.size = hit_size_q;
						wdata.tag  = hit_tag_q;
					end
				end
			end
			S_MOD: begin
				if (ins_q) begin
					ctl.cmd = CMD_INS;
					ctl.pos = POS_W'(del_pos_q);
				end else if (del_cnt_q != 2'd0) begin
					ctl.cmd = CMD_DEL;
					ctl.pos = POS_W'(del_pos_q);
				end
			end
			default: ctl.cmd = CMD_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			append_en_q  <= 1'b1;
			heap_bytes_q <= 17'd65536;
		end else if (cfg_we) begin
			if (cfg_index) heap_bytes_q <= cfg_data;
			else append_en_q <= cfg_data[0];
		end
	end

	// Request payload and walk bookkeeping
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q  <= s_tuser;
			req_q <= s_tdata[15:0];
			fa_q  <= s_tdata[31:16];
			tag_q <= s_tdata[39:32];
			idx_q <= '0;
			pos_q <= '0;
			prev_free_q <= 1'b0;
			prev_size_q <= '0;
			next_free_q <= 1'b0;
			next_size_q <= '0;
			need_next_q <= 1'b0;
		end else if (state_q == S_WALK) begin
			idx_q <= idx_q + IW'(1);
			if (need_next_q) begin
				need_next_q <= 1'b0;
				next_free_q <= head.free && cur_valid;
				next_size_q <= head.size;
			end
			if (!found_q && cur_valid) begin
				if (!op_q && fit) begin
					hit_idx_q  <= idx_q;
					hit_size_q <= head.size;
					hit_pos_q  <= pos_q;
				end else if (op_q && addr_match) begin
					hit_idx_q   <= idx_q;
					hit_size_q  <= head.size;
					hit_free_q  <= head.free;
					hit_tag_q   <= head.tag;
					need_next_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 18'(HEADER_BYTES) + {1'b0, head.size};
					prev_free_q <= head.free;
					prev_size_q <= head.size;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			found_q    <= 1'b0;
			count_q    <= '0;
			end_q      <= '0;
			ins_q      <= 1'b0;
			del_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && (!m_tvalid_q || m_tready)) m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						found_q <= 1'b0;
						if (!s_tuser && s_tdata[15:0] == 16'd0) begin
							resp_st_q   <= STAT_ZERO;
							resp_addr_q <= '0;
							state_q     <= S_RESP;
						end else if (s_tuser && {1'b0, s_tdata[31:16]} >= limit) begin
							resp_st_q   <= STAT_OUTSIDE;
							resp_addr_q <= '0;
							state_q     <= S_RESP;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (!found_q && cur_valid && ((!op_q && fit) || (op_q && addr_match)))
						found_q <= 1'b1;
					if (idx_q == LAST_IDX) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_MOD;
					if (!op_q) begin
						if (found_q) begin
							resp_st_q   <= STAT_OK;
							resp_addr_q <= 16'(hit_pos_q + 18'(HEADER_BYTES));
							if (hit_size_q != {1'b0, req_q}) begin
								// Split: free remainder goes right after the hit
								ins_q <= 1'b1;
								del_pos_q <= hit_idx_q + IW'(1);
								ins_data_q.size <= ES_W'(hit_size_q - {1'b0, req_q}
									- ES_W'(HEADER_BYTES));
								ins_data_q.free <= 1'b1;
								ins_data_q.tag  <= 8'd0;
								count_q <= count_q + CW'(1);
							end
						end else if (!append_en_q) begin
							resp_st_q   <= STAT_DISABLED;
							resp_addr_q <= '0;
						end else if (count_q >= CW'(MAX_ENTRIES) || !room_ok) begin
							resp_st_q   <= STAT_OOM;
							resp_addr_q <= '0;
						end else begin
							resp_st_q   <= STAT_OK;
							resp_addr_q <= 16'(end_q + 17'(HEADER_BYTES));
							end_q   <= 17'(end_q + 17'(HEADER_BYTES) + {1'b0, req_q});
							count_q <= count_q + CW'(1);
						end
					end else begin
						resp_addr_q <= '0;
						if (!found_q) begin
							resp_st_q <= STAT_NOENTRY;
						end else if (hit_free_q) begin
							resp_st_q <= STAT_DBLFREE;
						end else begin
							resp_st_q <= STAT_OK;
							if (prev_free_q && next_free_q) begin
								del_cnt_q <= 2'd2;
								del_pos_q <= hit_idx_q;
								count_q   <= count_q - CW'(2);
							end else if (prev_free_q) begin
								del_cnt_q <= 2'd1;
								del_pos_q <= hit_idx_q;
								count_q   <= count_q - CW'(1);
							end else if (next_free_q) begin
								del_cnt_q <= 2'd1;
								del_pos_q <= hit_idx_q + IW'(1);
								count_q   <= count_q - CW'(1);
							end
						end
					end
				end
				S_MOD: begin
					if (ins_q) ins_q <= 1'b0;
					else if (del_cnt_q != 2'd0) del_cnt_q <= del_cnt_q - 2'd1;
					else state_q <= S_RESP;
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!m_tvalid_q || m_tready)) begin
			out_addr_q <= resp_addr_q;
			out_st_q   <= resp_st_q;
		end
	end

	`FFHA_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES))
	`FFHA_ASSERT_IMP(a_fail_addr_zero, m_tvalid && m_tdata[18:16] != STAT_OK, m_tdata[15:0] == 16'd0)
	`FFHA_ASSERT_NXT(a_accept_next, s_acc, state_q == S_WALK || state_q == S_RESP)
	`FFHA_ASSERT_NXT(a_walk_full, state_q == S_WALK && idx_q != LAST_IDX, state_q == S_WALK)

endmodule
